>>> hw/rtl/skl_pkg.sv
`default_nettype none

package skl_pkg;

    // Fixed field widths and defaults
    localparam int DEPTH_DFLT = 32;
    localparam int KEY_CHARS  = 8;
    localparam int KEY_W      = 64;
    localparam int LETTER_W   = 8;
    localparam int COUNT_W    = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request codes carried on the input tuser
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_COUNT  = 2'd1,
        REQ_AFTER  = 2'd2,
        REQ_BEFORE = 2'd3
    } req_e_t;

    // Kind of result loaded into the output register
    typedef enum logic [2:0] {
        OUT_ACK,
        OUT_FULL,
        OUT_COUNT,
        OUT_MARK,
        OUT_ENTRY
    } out_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_req;
        logic      rd_en;
        logic      rd_below;
        logic      wr_en;
        logic      wr_src_key;
        logic      idx_inc;
        logic      idx_dec;
        logic      cnt_step;
        logic      commit;
        logic      range_set;
        logic      found;
        logic      out_load;
        out_kind_t out_kind;
        logic      out_last;
    } skl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic idx_zero;
        logic idx_at_n;
        logic rd_gt;
        logic rd_eq;
        logic range_empty;
        logic range_last;
        logic out_free;
    } skl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_key_list_query_unit.sv
// Sorted identifier table with insert, count-by-letter and range listings.
// Input channel s_*: one transaction per request; s_tuser selects the request,
// s_tdata carries the key (first character in the top byte) and the letter.
// Output channel m_*: one transaction per result; m_tlast marks the final
// result of a request. Insert and count give one result; a listing gives one
// result per listed entry, or a single marker with entry_valid low.
// The key store has a registered read, so each visited entry takes a read
// state and then a compare or output state:
//   insert: walk down from the end, shifting each larger key up one slot,
//           then write the key; a full table goes straight to the result
//   count : read every stored entry and compare its first letter
//   list  : search from slot 0 for the first equal key, then read and
//           output each listed entry, or output the marker
// One request is worked on at a time; s_tready is high only between requests.
// The output register holds a finished result, so a new request is taken
// while the last result still waits. A stalled receiver holds the block in
// place without losing a result. Reset empties the table immediately; the
// key store itself is not cleared.
`default_nettype none

module sorted_key_list_query_unit
    import skl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DFLT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // key[63:0], letter[71:64]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // entry_key[63:0], match_count[69:64], zero[71:70]
    output logic [1:0]       m_tuser,   // entry_valid[0], table_full[1]
    output logic             m_tlast    // last
);

    skl_cmd_t           cmd;
    skl_sts_t           sts;
    logic [KEY_W-1:0]   m_key;
    logic [COUNT_W-1:0] m_count;
    logic               m_entry_valid;
    logic               m_full;

    skl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_req    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    skl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_req         (s_tuser),
        .s_key         (s_tdata[63:0]),
        .s_letter      (s_tdata[71:64]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_key         (m_key),
        .m_count       (m_count),
        .m_entry_valid (m_entry_valid),
        .m_full        (m_full),
        .m_last        (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {2'b00, m_count, m_key};
    assign m_tuser = {m_full, m_entry_valid};

endmodule

`default_nettype wire

>>> hw/rtl/skl_datapath.sv
`default_nettype none

module skl_datapath
    import skl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DFLT
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [1:0]          s_req,
    input  wire logic [KEY_W-1:0]    s_key,
    input  wire logic [LETTER_W-1:0] s_letter,
    input  wire skl_cmd_t            cmd,
    output skl_sts_t                 sts,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [KEY_W-1:0]         m_key,
    output logic [COUNT_W-1:0]       m_count,
    output logic                     m_entry_valid,
    output logic                     m_full,
    output logic                     m_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [KEY_W-1:0]    mem [DEPTH];
    logic [KEY_W-1:0]    rd_data_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic [1:0]          req_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       end_reg, end_next;
    logic [CW-1:0]       n_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [KEY_W-1:0]    canon_key;
    logic [CW:0]         idx_plus;
    logic [CW-1:0]       rd_idx;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [KEY_W-1:0]    wr_data;
    logic                letter_hit;

    logic                out_valid_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_entry_reg;
    logic                out_full_reg;
    logic                out_last_reg;

    // Cut the key to KEY_CHARS and clear everything after the first zero byte
    always_comb
    begin
        logic       alive;
        logic [7:0] ch;
        alive     = 1'b1;
        canon_key = '0;
        for (int i = 0; i < 8; i++)
        begin
            ch = s_key[KEY_W-1-8*i -: 8];
            if (i >= KEY_CHARS || ch == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                canon_key[KEY_W-1-8*i -: 8] = ch;
            end
        end
    end

    // Addresses and write data
    assign rd_idx     = cmd.rd_below ? (idx_reg - CW'(1)) : idx_reg;
    assign rd_addr    = rd_idx[AW-1:0];
    assign wr_addr    = idx_reg[AW-1:0];
    assign wr_data    = cmd.wr_src_key ? key_reg : rd_data_reg;
    assign idx_plus   = {1'b0, idx_reg} + (CW+1)'(1);
    assign letter_hit = (rd_data_reg[KEY_W-1 -: LETTER_W] == letter_reg);

    // Key store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request payload latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg    <= canon_key;
            letter_reg <= s_letter;
            req_reg    <= s_req;
        end
    end

    // Scan index and range end
    always_comb
    begin
        idx_next = idx_reg;
        end_next = end_reg;
        priority if (cmd.load_req)
        begin
            idx_next = (s_req == REQ_INSERT) ? n_reg : '0;
        end
        else if (cmd.range_set)
        begin
            if (req_reg == REQ_AFTER)
            begin
                idx_next = cmd.found ? idx_plus[CW-1:0] : '0;
                end_next = cmd.found ? n_reg : '0;
            end
            else
            begin
                idx_next = '0;
                end_next = idx_reg;
            end
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus[CW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            end_reg <= '0;
            n_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            end_reg <= end_next;
            if (cmd.commit)
            begin
                n_reg <= n_reg + CW'(1);
            end
            if (cmd.load_req)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_step && letter_hit && cnt_reg != COUNT_MAX)
            begin
                cnt_reg <= cnt_reg + COUNT_W'(1);
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_key_reg   <= (cmd.out_kind == OUT_ENTRY) ? rd_data_reg : '0;
            out_entry_reg <= (cmd.out_kind == OUT_ENTRY);
            out_full_reg  <= (cmd.out_kind == OUT_FULL);
            out_count_reg <= (cmd.out_kind == OUT_COUNT) ? cnt_reg : '0;
            out_last_reg  <= cmd.out_last;
        end
    end

    // Status
    assign sts.full        = (n_reg == DEPTH_C);
    assign sts.idx_zero    = (idx_reg == '0);
    assign sts.idx_at_n    = (idx_reg == n_reg);
    assign sts.rd_gt       = (rd_data_reg > key_reg);
    assign sts.rd_eq       = (rd_data_reg == key_reg);
    assign sts.range_empty = (idx_reg >= end_reg);
    assign sts.range_last  = (idx_plus == {1'b0, end_reg});
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign m_key         = out_key_reg;
    assign m_count       = out_count_reg;
    assign m_entry_valid = out_entry_reg;
    assign m_full        = out_full_reg;
    assign m_last        = out_last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("pending result overwritten");

    a_entry_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_entry_reg |-> !out_full_reg && out_count_reg == '0)
        else $error("listed entry carries count or full flag");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !sts.full)
        else $error("insert committed into a full table");

endmodule

`default_nettype wire

>>> hw/rtl/skl_ctrl.sv
`default_nettype none

module skl_ctrl
    import skl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic [1:0] s_req,
    input  wire skl_sts_t sts,
    output skl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_CNT_RD,
        ST_CNT_CMP,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_RESULT
    } state_t;

    state_t    state_reg, state_next;
    out_kind_t kind_reg, kind_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.out_kind = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    unique case (s_req)
                        REQ_INSERT:
                        begin
                            if (sts.full)
                            begin
                                kind_next  = OUT_FULL;
                                state_next = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_INS_RD;
                            end
                        end
                        REQ_COUNT:
                        begin
                            state_next = ST_CNT_RD;
                        end
                        default:
                        begin
                            state_next = ST_SRCH_RD;
                        end
                    endcase
                end
            end
            // Walk down from the end, shifting larger keys up one slot
            ST_INS_RD:
            begin
                if (sts.idx_zero)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_src_key = 1'b1;
                    cmd.commit     = 1'b1;
                    kind_next      = OUT_ACK;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_below = 1'b1;
                    state_next   = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt)
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = ST_INS_RD;
                end
                else
                begin
                    cmd.wr_src_key = 1'b1;
                    cmd.commit     = 1'b1;
                    kind_next      = OUT_ACK;
                    state_next     = ST_RESULT;
                end
            end
            // Count keys by first letter
            ST_CNT_RD:
            begin
                if (sts.idx_at_n)
                begin
                    kind_next  = OUT_COUNT;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CNT_CMP;
                end
            end
            ST_CNT_CMP:
            begin
                cmd.cnt_step = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = ST_CNT_RD;
            end
            // Search for the first equal key
            ST_SRCH_RD:
            begin
                if (sts.idx_at_n)
                begin
                    cmd.range_set = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                if (sts.rd_eq)
                begin
                    cmd.range_set = 1'b1;
                    cmd.found     = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            // Emit the selected range, or a marker when it is empty
            ST_EMIT_RD:
            begin
                if (sts.range_empty)
                begin
                    kind_next  = OUT_MARK;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_ENTRY;
                    cmd.out_last = sts.range_last;
                    if (sts.range_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= OUT_ACK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire
